### rtl/core/sha1bs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream package
// Payload structs, controller state, command/status structs and constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1bs_pkg;

	typedef enum logic {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word0;
		logic [31:0] digest_word1;
		logic [31:0] digest_word2;
		logic [31:0] digest_word3;
		logic [31:0] digest_word4;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_LEN,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic store_byte;   // shift data byte into window, bump count
		logic start_block;  // load working vars from chain
		logic round_step;   // one round
		logic fold;         // add working vars into chain
		logic pad_byte;     // shift in one padding byte, advance pad pointer
		logic pad_len;      // padding byte comes from the bit length
		logic pad_start;    // shift in pad marker, pad pointer to next slot
		logic reset_msg;    // chain and count back to initial
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic block_full;   // next byte written goes to slot 63
		logic last_round;   // round counter at 79
		logic pad_at_56;    // pad pointer reached the length field
		logic pad_at_0;     // pad pointer wrapped to a new block
		logic pad_done;     // pad pointer at the last byte of the final block
	} status_t;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [7:0]  PAD_MARK = 8'h80;

endpackage

### rtl/core/sha1_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Absorbs one message byte per word, emits the 160-bit digest on finish.
// ----------------------------------------------------------------------------
// An absorb word stores one byte; the 64th byte of a block starts the
// compression, which runs one SHA-1 round per cycle in a single round unit
// and holds input off until the fold. A finish word writes padding one
// byte per cycle (plus a second block when more than 55 bytes are
// pending), compresses each padded block and loads the digest register,
// which then waits for the consumer while new bytes are taken.
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha1bs_pkg::in_word_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha1bs_pkg::out_word_t out_data
);
	import sha1bs_pkg::*;

	cmd_t    cmd;
	status_t sts;

	sha1bs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_data.opcode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	sha1bs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (in_data.data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.digest    (out_data)
	);

	// datapath never gets two exclusive operations at once
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.round_step, cmd.fold, cmd.pad_byte, cmd.reset_msg}) <= 1)
		else $error("conflicting datapath commands");

	// digest register loads only when it is free
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reset_msg |-> (!out_valid || out_ready))
		else $error("digest overwritten before taken");

	// a new result follows a reset of the message state
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.reset_msg))
		else $error("result without finish");

endmodule

### rtl/core/sha1bs_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream controller
// Sequences byte stores, round iteration, padding and digest handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1bs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output sha1bs_pkg::cmd_t    cmd,
	input  sha1bs_pkg::status_t sts
);
	import sha1bs_pkg::*;

	state_t state_q, state_d;
	logic   final_q, final_d;   // block being hashed is the last of a message
	logic   padx_q, padx_d;     // extra padding block already sent to compression
	logic   outv_q, outv_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
			padx_q  <= 1'b0;
			outv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
			padx_q  <= padx_d;
			outv_q  <= outv_d;
		end
	end

	assign out_valid = outv_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		final_d  = final_q;
		padx_d   = padx_q;
		outv_d   = outv_q && !out_ready;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// a digest register holds one result; finish waits for it to drain
				in_ready = !(in_op == OP_FINISH && outv_q);
				if (in_valid && in_ready) begin
					if (in_op == OP_ABSORB) begin
						cmd.store_byte = 1'b1;
						if (sts.block_full) begin
							cmd.start_block = 1'b1;
							final_d = 1'b0;
							state_d = ST_ROUND;
						end
					end else begin
						cmd.pad_start = 1'b1;
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
				if (sts.last_round) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (final_q) state_d = ST_OUT;
				else if (padx_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_PAD: begin
				// zero fill up to the length field, or to block end and compress that block
				if (sts.pad_at_0 && !padx_q) begin
					cmd.start_block = 1'b1;
					final_d = 1'b0;
					padx_d = 1'b1;
					state_d = ST_ROUND;
				end else if (sts.pad_at_56) begin
					state_d = ST_LEN;
				end else begin
					cmd.pad_byte = 1'b1;
				end
			end
			ST_LEN: begin
				cmd.pad_byte = 1'b1;
				cmd.pad_len = 1'b1;
				if (sts.pad_done) begin
					cmd.start_block = 1'b1;
					final_d = 1'b1;
					padx_d = 1'b0;
					state_d = ST_ROUND;
				end
			end
			ST_OUT: begin
				cmd.reset_msg = 1'b1;
				outv_d = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### rtl/core/sha1bs_dp.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream datapath
// Byte window that doubles as message schedule, round unit and chaining words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1bs_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  sha1bs_pkg::cmd_t      cmd,
	output sha1bs_pkg::status_t   sts,
	output sha1bs_pkg::out_word_t digest
);
	import sha1bs_pkg::*;

	logic [63:0]  count_q;
	logic [5:0]   ptr_q;          // pad pointer
	logic [6:0]   rnd_q;
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [511:0] w_q;            // bytes shift in at the bottom; w[t] at the top
	logic [31:0]  dig_q [5];

	logic [5:0]   slot;
	logic [63:0]  bits;
	logic [7:0]   pad_val;
	logic [31:0]  f, k, t, w_new, wt;

	assign slot = count_q[5:0];
	assign bits = {count_q[60:0], 3'b000};

	// padding byte: zero, or length byte for pointer position
	always_comb begin
		if (cmd.pad_len) pad_val = bits[8*(63-ptr_q) +: 8];
		else pad_val = 8'h00;
	end

	// round function
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = d_q ^ (b_q & (c_q ^ d_q));
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (d_q & (b_q | c_q));
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		wt = w_q[511:480];
		t = {a_q[26:0], a_q[31:27]} + f + e_q + wt + k;
	end

	// next schedule word from window taps t-3, t-8, t-14, t-16
	logic [31:0] wx;
	assign wx = w_q[95:64] ^ w_q[255:224] ^ w_q[447:416] ^ w_q[511:480];
	assign w_new = {wx[30:0], wx[31]};

	assign sts.block_full = (slot == 6'd63);
	assign sts.last_round = (rnd_q == 7'd79);
	assign sts.pad_at_56  = (ptr_q == 6'd56);
	assign sts.pad_at_0   = (ptr_q == 6'd0);
	assign sts.pad_done   = (ptr_q == 6'd63);

	// byte count, pad pointer, round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			rnd_q   <= '0;
		end else begin
			if (cmd.reset_msg) count_q <= '0;
			else if (cmd.store_byte) count_q <= count_q + 64'd1;
			if (cmd.pad_start) ptr_q <= slot + 6'd1;
			else if (cmd.pad_byte) ptr_q <= ptr_q + 6'd1;
			if (cmd.start_block) rnd_q <= '0;
			else if (cmd.round_step) rnd_q <= rnd_q + 7'd1;
		end
	end

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
		end else if (cmd.reset_msg) begin
			h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
		end else if (cmd.fold) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

	// byte window and schedule, working vars, digest capture
	always_ff @(posedge clk) begin
		// 64 byte shifts fill a block; rounds then extend it in place
		if (cmd.store_byte) w_q <= {w_q[503:0], data_byte};
		else if (cmd.pad_start) w_q <= {w_q[503:0], PAD_MARK};
		else if (cmd.pad_byte) w_q <= {w_q[503:0], pad_val};
		else if (cmd.round_step) w_q <= {w_q[479:0], w_new};
		if (cmd.start_block) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
		end else if (cmd.round_step) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t;
		end
		if (cmd.reset_msg) begin
			for (int i = 0; i < 5; i++) dig_q[i] <= h_q[i];
		end
	end

	assign digest.digest_word0 = dig_q[0];
	assign digest.digest_word1 = dig_q[1];
	assign digest.digest_word2 = dig_q[2];
	assign digest.digest_word3 = dig_q[3];
	assign digest.digest_word4 = dig_q[4];

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Streams random and directed messages into the hasher, predicts each digest
// with a behavioral SHA-1 model and checks every digest word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// digest prediction and checking
class sha1_digest_board;
	logic [31:0] chain [5];
	logic [7:0]  blk [64];
	logic [63:0] nbytes;
	sha1bs_pkg::out_word_t pending [$];
	int errors;
	int digests;

	function new();
		errors = 0;
		digests = 0;
		restart();
	endfunction

	function void restart();
		chain[0] = sha1bs_pkg::H0;
		chain[1] = sha1bs_pkg::H1;
		chain[2] = sha1bs_pkg::H2;
		chain[3] = sha1bs_pkg::H3;
		chain[4] = sha1bs_pkg::H4;
		nbytes = '0;
	endfunction

	static function logic [31:0] rol(logic [31:0] x, int k);
		return (x << k) | (x >> (32 - k));
	endfunction

	function void compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = d ^ (b & (c ^ d)); k = sha1bs_pkg::K0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = sha1bs_pkg::K1;
			end else if (i < 60) begin
				f = (b & c) | (d & (b | c)); k = sha1bs_pkg::K2;
			end else begin
				f = b ^ c ^ d; k = sha1bs_pkg::K3;
			end
			t = rol(a, 5) + f + e + w[i] + k;
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endfunction

	// note one accepted input word
	function void note_input(sha1bs_pkg::in_word_t wd);
		int r;
		logic [63:0] bits;
		r = nbytes[5:0];
		if (wd.opcode == sha1bs_pkg::OP_ABSORB) begin
			blk[r] = wd.data_byte;
			nbytes++;
			if (r == 63)
				compress();
			return;
		end
		bits = nbytes << 3;
		blk[r] = sha1bs_pkg::PAD_MARK;
		r++;
		if (r > 56) begin
			for (int i = r; i < 64; i++) blk[i] = 8'h00;
			compress();
			r = 0;
		end
		for (int i = r; i < 56; i++) blk[i] = 8'h00;
		for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
		compress();
		pending.push_back({chain[0], chain[1], chain[2], chain[3], chain[4]});
		restart();
	endfunction

	// check one accepted digest
	function void check_digest(sha1bs_pkg::out_word_t got);
		sha1bs_pkg::out_word_t exp;
		if (pending.size() == 0) begin
			$display("%0t unexpected digest %h", $time, got);
			errors++;
			return;
		end
		exp = pending.pop_front();
		digests++;
		if (got.digest_word0 !== exp.digest_word0 || got.digest_word1 !== exp.digest_word1 ||
		    got.digest_word2 !== exp.digest_word2 || got.digest_word3 !== exp.digest_word3 ||
		    got.digest_word4 !== exp.digest_word4) begin
			$display("%0t digest mismatch exp %h got %h", $time, exp, got);
			errors++;
		end
	endfunction
endclass

module tb_top;
	import sha1bs_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	sha1_digest_board board;
	int snd_idle_pct;
	int rcv_idle_pct;
	bit rcv_hold;
	int words_sent;

	sha1_byte_stream_hasher_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	// send one word, with optional idle cycles ahead of it
	task automatic send_word(op_t op, logic [7:0] b);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{opcode: op, data_byte: b};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(in_data);
		words_sent++;
	endtask

	task automatic send_msg(int len, bit fixed, logic [7:0] val);
		for (int i = 0; i < len; i++)
			send_word(OP_ABSORB, fixed ? val : 8'($urandom));
		send_word(OP_FINISH, 8'($urandom));
	endtask

	task automatic drain();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (board.pending.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
	endtask

	function automatic int pick_len();
		int s;
		s = $urandom_range(99);
		if (s < 30) return $urandom_range(54, 66);
		if (s < 45) return $urandom_range(118, 130);
		if (s < 55) return $urandom_range(0, 3);
		return $urandom_range(0, 70);
	endfunction

	// receiver: random stalls, plus a long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !rcv_hold && ($urandom_range(99) >= rcv_idle_pct);
			if (out_valid && out_ready)
				board.check_digest(out_data);
		end
	end

	initial begin
		board = new();
		in_valid = 1'b0;
		in_data = '0;
		rcv_hold = 1'b0;
		words_sent = 0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, extreme and alternating byte values, abc
		send_msg(0, 1, 8'h00);
		send_msg(1, 1, 8'hFF);
		send_msg(3, 1, 8'h00);
		send_msg(1, 1, 8'hA5);
		send_msg(1, 1, 8'h5A);
		send_word(OP_ABSORB, 8'h61); send_word(OP_ABSORB, 8'h62);
		send_word(OP_ABSORB, 8'h63); send_word(OP_FINISH, 8'hFF);
		drain();

		// phase one: sender idles lightly, receiver heavily
		snd_idle_pct = 19;
		rcv_idle_pct = 51;
		send_msg(55, 0, 0);
		send_msg(56, 0, 0);
		send_msg(63, 0, 0);
		send_msg(64, 0, 0);
		while (words_sent < 600) send_msg(pick_len(), 0, 0);

		// long receiver hold while messages keep coming
		rcv_hold = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				rcv_hold = 1'b0;
			end
			begin
				send_msg(2, 0, 0); send_msg(0, 0, 0); send_msg(5, 0, 0);
			end
		join
		drain();

		// phase two: roles swapped
		snd_idle_pct = 51;
		rcv_idle_pct = 19;
		while (words_sent < 1150) send_msg(pick_len(), 0, 0);
		drain();

		// phase three: no idling
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		while (words_sent < 1600) send_msg(pick_len(), 0, 0);

		drain();
		repeat (400) @(posedge clk);
		$display("covered %0d input words and %0d digests, message lengths 0 to 130 bytes",
		         words_sent, board.digests);
		$display("padding edges, empty messages and long output stalls included");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

### filelist.f
rtl/core/sha1bs_pkg.sv
rtl/core/sha1bs_ctrl.sv
rtl/core/sha1bs_dp.sv
rtl/core/sha1_byte_stream_hasher_unit.sv
bench/tb_top.sv
